>>> rtl/core/prd_pkg.sv
// prd_pkg: shared constants for the priority runway dispatcher.
// Port widths, parameter defaults and item mode codes.
// No dependencies.
`default_nettype none

package prd_pkg;

	// parameter defaults
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 16;
	localparam int ID_BITS_MAX     = 32;

	// fixed port widths
	localparam int ID_W     = 16;
	localparam int PRIO_W   = 3;
	localparam int COUNT_W  = 5;
	localparam int SERVED_W = 16;
	localparam int MODE_W   = 2;

	// item modes
	localparam logic [MODE_W-1:0] MODE_DEP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

	// servers: the last one prefers the departure FIFO
	localparam int NUM_SRV              = 3;
	localparam logic [1:0] SRV_FIRST    = 2'd0;
	localparam logic [1:0] SRV_LAST     = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/priority_runway_dispatcher.sv
// priority_runway_dispatcher: top level, sequencer plus two queue memories.
// Depends on prd_pkg, prd_ram, prd_seq.
//
// Usage:
//   An item is taken at a clock edge where start is high and busy is low.
//   mode selects: enqueue departure (FIFO), enqueue arrival (sorted by
//   req_priority, lower first, stable among equals), or dispatch tick.
//   Each item gives exactly one result, shown for one cycle with done high;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   busy is low during the done cycle, so the next item may be taken at the
//   edge that ends it.
// Steps from the accept edge to the done cycle:
//   rejected enqueue or unused mode: done is registered at the accept edge
//   departure enqueue: one write state, then done
//   arrival enqueue: a setup state; into an empty queue straight to the write
//     state, else a read state, then compare steps that move each larger
//     priority up one slot until one is lower or equal or the walk reaches
//     the head, then the write state; the walk makes one memory read per step
//   tick: per server, a read state, then a take state if it finds a request
// Reset clears both fill counts, the heads and the served counter; no
// clearing pass over the memories is needed.
`default_nettype none

module priority_runway_dispatcher #(
	parameter int QUEUE_DEPTH = prd_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = prd_pkg::ID_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	output logic                              done,
	input  wire logic [prd_pkg::MODE_W-1:0]   mode,
	input  wire logic [prd_pkg::ID_W-1:0]     req_id,
	input  wire logic [prd_pkg::PRIO_W-1:0]   req_priority,
	output logic                              accepted,
	output logic      [prd_pkg::ID_W-1:0]     srv1_id,
	output logic                              srv1_from_arrival,
	output logic      [prd_pkg::ID_W-1:0]     srv2_id,
	output logic                              srv2_from_arrival,
	output logic      [prd_pkg::ID_W-1:0]     srv3_id,
	output logic                              srv3_from_arrival,
	output logic      [prd_pkg::SERVED_W-1:0] served_total,
	output logic      [prd_pkg::COUNT_W-1:0]  arrival_count,
	output logic      [prd_pkg::COUNT_W-1:0]  departure_count
);

	import prd_pkg::*;

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int AWORD = ID_BITS + PRIO_W;

	logic             arr_we;
	logic [AW-1:0]    arr_waddr;
	logic [AWORD-1:0] arr_wdata;
	logic [AW-1:0]    arr_raddr;
	logic [AWORD-1:0] arr_rdata;
	logic             dep_we;
	logic [AW-1:0]    dep_waddr;
	logic [ID_BITS-1:0] dep_wdata;
	logic [AW-1:0]    dep_raddr;
	logic [ID_BITS-1:0] dep_rdata;

	prd_seq #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.done             (done),
		.mode             (mode),
		.req_id           (req_id),
		.req_priority     (req_priority),
		.accepted         (accepted),
		.srv1_id          (srv1_id),
		.srv1_from_arrival(srv1_from_arrival),
		.srv2_id          (srv2_id),
		.srv2_from_arrival(srv2_from_arrival),
		.srv3_id          (srv3_id),
		.srv3_from_arrival(srv3_from_arrival),
		.served_total     (served_total),
		.arrival_count    (arrival_count),
		.departure_count  (departure_count),
		.arr_we           (arr_we),
		.arr_waddr        (arr_waddr),
		.arr_wdata        (arr_wdata),
		.arr_raddr        (arr_raddr),
		.arr_rdata        (arr_rdata),
		.dep_we           (dep_we),
		.dep_waddr        (dep_waddr),
		.dep_wdata        (dep_wdata),
		.dep_raddr        (dep_raddr),
		.dep_rdata        (dep_rdata)
	);

	prd_ram #(
		.WIDTH(AWORD),
		.DEPTH(QUEUE_DEPTH)
	) u_arr_ram (
		.clk  (clk),
		.we   (arr_we),
		.waddr(arr_waddr),
		.wdata(arr_wdata),
		.raddr(arr_raddr),
		.rdata(arr_rdata)
	);

	prd_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_dep_ram (
		.clk  (clk),
		.we   (dep_we),
		.waddr(dep_waddr),
		.wdata(dep_wdata),
		.raddr(dep_raddr),
		.rdata(dep_rdata)
	);

endmodule

`default_nettype wire

>>> rtl/core/prd_ram.sv
// prd_ram: simple dual-port memory, one write and one registered read per cycle.
// Holds the entries of one request queue. No package dependency.
`default_nettype none

module prd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/prd_seq.sv
// prd_seq: sequencer of the dispatcher: queue pointers, fill counts, served counter,
// sorted insertion walk and the three-server dispatch. Drives both queue memories.
// Depends on prd_pkg.
`default_nettype none

module prd_seq #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	output logic                                 done,
	input  wire logic [prd_pkg::MODE_W-1:0]      mode,
	input  wire logic [prd_pkg::ID_W-1:0]        req_id,
	input  wire logic [prd_pkg::PRIO_W-1:0]      req_priority,
	output logic                                 accepted,
	output logic      [prd_pkg::ID_W-1:0]        srv1_id,
	output logic                                 srv1_from_arrival,
	output logic      [prd_pkg::ID_W-1:0]        srv2_id,
	output logic                                 srv2_from_arrival,
	output logic      [prd_pkg::ID_W-1:0]        srv3_id,
	output logic                                 srv3_from_arrival,
	output logic      [prd_pkg::SERVED_W-1:0]    served_total,
	output logic      [prd_pkg::COUNT_W-1:0]     arrival_count,
	output logic      [prd_pkg::COUNT_W-1:0]     departure_count,
	// arrival memory: {id, priority}
	output logic                                 arr_we,
	output logic      [$clog2(QUEUE_DEPTH)-1:0]  arr_waddr,
	output logic      [ID_BITS+prd_pkg::PRIO_W-1:0] arr_wdata,
	output logic      [$clog2(QUEUE_DEPTH)-1:0]  arr_raddr,
	input  wire logic [ID_BITS+prd_pkg::PRIO_W-1:0] arr_rdata,
	// departure memory
	output logic                                 dep_we,
	output logic      [$clog2(QUEUE_DEPTH)-1:0]  dep_waddr,
	output logic      [ID_BITS-1:0]              dep_wdata,
	output logic      [$clog2(QUEUE_DEPTH)-1:0]  dep_raddr,
	input  wire logic [ID_BITS-1:0]              dep_rdata
);

	import prd_pkg::*;

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int AWORD = ID_BITS + PRIO_W;

	localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEP_PUT,
		ST_INS_SETUP,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_SRV_RD,
		ST_SRV_TAKE
	} state_t;

	// (a + b) mod depth, with a < depth and b <= depth
	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(QUEUE_DEPTH)) begin
			s = s - (CW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST_C) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST_C : p - 1'b1;
	endfunction

	state_t                state_q;
	logic [AW-1:0]         arr_head_q;
	logic [CW-1:0]         arr_fill_q;
	logic [AW-1:0]         dep_head_q;
	logic [CW-1:0]         dep_fill_q;
	logic [SERVED_W-1:0]   served_q;
	logic                  done_q;
	logic                  accepted_q;
	logic [ID_W-1:0]       srv_id_q  [NUM_SRV];
	logic                  srv_arr_q [NUM_SRV];
	logic [1:0]            srv_q;
	logic                  sel_arr_q;
	logic [ID_BITS-1:0]    id_q;
	logic [PRIO_W-1:0]     prio_q;
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         rp_q;
	logic [CW-1:0]         k_q;

	logic [ID_BITS_MAX+ID_W-1:0] id_wide;
	logic [ID_BITS-1:0]          id_in;
	logic [ID_BITS-1:0]          arr_rd_id;
	logic [PRIO_W-1:0]           arr_rd_prio;
	logic [ID_BITS-1:0]          take_id;
	logic [ID_W+ID_BITS-1:0]     take_wide;
	logic                        shift;
	logic                        arr_has;
	logic                        dep_has;
	logic                        pick_arr;
	logic                        mode_arr;
	logic [AW-1:0]               tail;
	logic [CW+COUNT_W-1:0]       arr_cnt_wide;
	logic [CW+COUNT_W-1:0]       dep_cnt_wide;

	assign id_wide     = {{ID_BITS_MAX{1'b0}}, req_id};
	assign id_in       = id_wide[ID_BITS-1:0];
	assign arr_rd_id   = arr_rdata[AWORD-1:PRIO_W];
	assign arr_rd_prio = arr_rdata[PRIO_W-1:0];
	assign take_id     = sel_arr_q ? arr_rd_id : dep_rdata;
	assign take_wide   = {{ID_W{1'b0}}, take_id};
	assign shift       = (arr_rd_prio > prio_q);
	assign arr_has     = (arr_fill_q != '0);
	assign dep_has     = (dep_fill_q != '0);
	// servers 1 and 2 prefer arrivals, server 3 prefers departures
	assign pick_arr    = arr_has && ((srv_q != SRV_LAST) || !dep_has);
	assign mode_arr    = (mode == MODE_ARR);
	// one adder finds the tail slot of whichever queue takes the item
	assign tail        = ptr_add(mode_arr ? arr_head_q : dep_head_q,
				mode_arr ? arr_fill_q : dep_fill_q);

	// memory control
	assign arr_we    = ((state_q == ST_INS_CMP) && shift) || (state_q == ST_INS_PUT);
	assign arr_waddr = wp_q;
	assign arr_wdata = (state_q == ST_INS_PUT) ? {id_q, prio_q} : arr_rdata;
	assign dep_we    = (state_q == ST_DEP_PUT);
	assign dep_waddr = wp_q;
	assign dep_wdata = id_q;
	assign dep_raddr = dep_head_q;

	always_comb begin
		unique case (state_q)
			ST_INS_RD:  arr_raddr = rp_q;
			ST_INS_CMP: arr_raddr = ptr_dec(rp_q);
			default:    arr_raddr = arr_head_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			arr_head_q <= '0;
			arr_fill_q <= '0;
			dep_head_q <= '0;
			dep_fill_q <= '0;
			served_q   <= '0;
			done_q     <= 1'b0;
			accepted_q <= 1'b0;
			srv_q      <= SRV_FIRST;
			sel_arr_q  <= 1'b0;
			id_q       <= '0;
			prio_q     <= '0;
			wp_q       <= '0;
			rp_q       <= '0;
			k_q        <= '0;
			for (int i = 0; i < NUM_SRV; i++) begin
				srv_id_q[i]  <= '0;
				srv_arr_q[i] <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						id_q       <= id_in;
						prio_q     <= req_priority;
						wp_q       <= tail;
						accepted_q <= 1'b0;
						srv_q      <= SRV_FIRST;
						for (int i = 0; i < NUM_SRV; i++) begin
							srv_id_q[i]  <= '0;
							srv_arr_q[i] <= 1'b0;
						end
						priority if (mode == MODE_DEP) begin
							if ((id_in != '0) && (dep_fill_q != DEPTH_C)) begin
								state_q <= ST_DEP_PUT;
							end else begin
								done_q <= 1'b1;
							end
						end else if (mode == MODE_ARR) begin
							if ((id_in != '0) && (arr_fill_q != DEPTH_C)) begin
								state_q <= ST_INS_SETUP;
							end else begin
								done_q <= 1'b1;
							end
						end else if (mode == MODE_TICK) begin
							accepted_q <= 1'b1;
							state_q    <= ST_SRV_RD;
						end else begin
							// unused mode: report counts only
							done_q <= 1'b1;
						end
					end
				end
				ST_DEP_PUT: begin
					dep_fill_q <= dep_fill_q + 1'b1;
					accepted_q <= 1'b1;
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_INS_SETUP: begin
					k_q  <= arr_fill_q;
					rp_q <= ptr_dec(wp_q);
					state_q <= (arr_fill_q == '0) ? ST_INS_PUT : ST_INS_RD;
				end
				ST_INS_RD: begin
					state_q <= ST_INS_CMP;
				end
				ST_INS_CMP: begin
					// walk from the tail toward the head, moving larger priorities up
					if (shift) begin
						wp_q <= rp_q;
						rp_q <= ptr_dec(rp_q);
						k_q  <= k_q - 1'b1;
						if (k_q == ONE_C) begin
							state_q <= ST_INS_PUT;
						end
					end else begin
						state_q <= ST_INS_PUT;
					end
				end
				ST_INS_PUT: begin
					arr_fill_q <= arr_fill_q + 1'b1;
					accepted_q <= 1'b1;
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_SRV_RD: begin
					if (arr_has || dep_has) begin
						sel_arr_q <= pick_arr;
						state_q   <= ST_SRV_TAKE;
					end else if (srv_q == SRV_LAST) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						srv_q <= srv_q + 1'b1;
					end
				end
				ST_SRV_TAKE: begin
					srv_id_q[srv_q]  <= take_wide[ID_W-1:0];
					srv_arr_q[srv_q] <= sel_arr_q;
					if (sel_arr_q) begin
						arr_head_q <= ptr_inc(arr_head_q);
						arr_fill_q <= arr_fill_q - 1'b1;
					end else begin
						dep_head_q <= ptr_inc(dep_head_q);
						dep_fill_q <= dep_fill_q - 1'b1;
					end
					if (served_q != '1) begin
						served_q <= served_q + 1'b1;
					end
					if (srv_q == SRV_LAST) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						srv_q   <= srv_q + 1'b1;
						state_q <= ST_SRV_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign arr_cnt_wide = {{COUNT_W{1'b0}}, arr_fill_q};
	assign dep_cnt_wide = {{COUNT_W{1'b0}}, dep_fill_q};

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign accepted          = accepted_q;
	assign srv1_id           = srv_id_q[0];
	assign srv1_from_arrival = srv_arr_q[0];
	assign srv2_id           = srv_id_q[1];
	assign srv2_from_arrival = srv_arr_q[1];
	assign srv3_id           = srv_id_q[2];
	assign srv3_from_arrival = srv_arr_q[2];
	assign served_total      = served_q;
	assign arrival_count     = arr_cnt_wide[COUNT_W-1:0];
	assign departure_count   = dep_cnt_wide[COUNT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/prd_checker.sv
// prd_checker: port-level checks of the dispatcher's command handshake and results.
// Bound to priority_runway_dispatcher. Depends on prd_pkg.
`default_nettype none

module prd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic                         accepted,
	input wire logic [prd_pkg::ID_W-1:0]     srv1_id,
	input wire logic [prd_pkg::ID_W-1:0]     srv2_id,
	input wire logic [prd_pkg::ID_W-1:0]     srv3_id
);

	import prd_pkg::*;

	// result is never shown while an item is still in work
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a taken item either keeps the block busy or finishes at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("item taken but no work or result followed");

	// leaving the busy phase always delivers a result
	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// rejected or unused items serve nobody
	a_reject_idle_servers: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> (srv1_id == '0 && srv2_id == '0 && srv3_id == '0))
		else $error("server id on a rejected item");

endmodule

bind priority_runway_dispatcher prd_checker u_prd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.accepted(accepted),
	.srv1_id (srv1_id),
	.srv2_id (srv2_id),
	.srv3_id (srv3_id)
);

`default_nettype wire

>>> dv/priority_runway_dispatcher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_runway_dispatcher: directed items, random traffic
// under several sender idle rates, and a short mixed tail.
// Depends on prd_pkg and the priority_runway_dispatcher RTL.

module priority_runway_dispatcher_tb;
	import prd_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int DEPTH      = QUEUE_DEPTH_DEF;
	localparam int SERVED_MAX = (1 << SERVED_W) - 1;
	localparam int LIMIT      = 8_000_000;
	localparam int MAX_GAP    = 40;

	typedef struct packed {
		logic                accepted;
		logic [ID_W-1:0]     srv1_id;
		logic                srv1_arr;
		logic [ID_W-1:0]     srv2_id;
		logic                srv2_arr;
		logic [ID_W-1:0]     srv3_id;
		logic                srv3_arr;
		logic [SERVED_W-1:0] served_total;
		logic [COUNT_W-1:0]  arrival_count;
		logic [COUNT_W-1:0]  departure_count;
	} dispatch_t;

	// Mirrors both queues and the served counter; holds the results still due.
	class dispatch_tracker;
		logic [ID_W-1:0]   arr_id [DEPTH];
		logic [PRIO_W-1:0] arr_pr [DEPTH];
		logic [ID_W-1:0]   dep_id [DEPTH];
		int                arr_fill;
		int                dep_head;
		int                dep_fill;
		int                served;
		int                mismatches;
		dispatch_t         due[$];

		function new();
			arr_fill   = 0;
			dep_head   = 0;
			dep_fill   = 0;
			served     = 0;
			mismatches = 0;
		endfunction

		function void count_served();
			if (served < SERVED_MAX) begin
				served++;
			end
		endfunction

		function logic [ID_W-1:0] pop_arrival();
			logic [ID_W-1:0] id;
			id = arr_id[0];
			for (int k = 1; k < arr_fill; k++) begin
				arr_id[k-1] = arr_id[k];
				arr_pr[k-1] = arr_pr[k];
			end
			arr_fill--;
			count_served();
			return id;
		endfunction

		function logic [ID_W-1:0] pop_departure();
			logic [ID_W-1:0] id;
			id = dep_id[dep_head];
			dep_head = (dep_head + 1) % DEPTH;
			dep_fill--;
			count_served();
			return id;
		endfunction

		function void serve(input bit arrival_first, output logic [ID_W-1:0] id,
				output logic from_arr);
			id = '0;
			from_arr = 1'b0;
			if (arrival_first && arr_fill > 0) begin
				id = pop_arrival();
				from_arr = 1'b1;
			end else if (dep_fill > 0) begin
				id = pop_departure();
			end else if (!arrival_first && arr_fill > 0) begin
				id = pop_arrival();
				from_arr = 1'b1;
			end
		endfunction

		function void note_item(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
				logic [PRIO_W-1:0] pr);
			dispatch_t r;
			int pos;
			r = '0;
			case (m)
			MODE_DEP: begin
				if (id != 0 && dep_fill < DEPTH) begin
					dep_id[(dep_head + dep_fill) % DEPTH] = id;
					dep_fill++;
					r.accepted = 1'b1;
				end
			end
			MODE_ARR: begin
				if (id != 0 && arr_fill < DEPTH) begin
					// stable: goes behind every entry of equal priority
					pos = 0;
					while (pos < arr_fill && arr_pr[pos] <= pr) begin
						pos++;
					end
					for (int k = arr_fill; k > pos; k--) begin
						arr_id[k] = arr_id[k-1];
						arr_pr[k] = arr_pr[k-1];
					end
					arr_id[pos] = id;
					arr_pr[pos] = pr;
					arr_fill++;
					r.accepted = 1'b1;
				end
			end
			MODE_TICK: begin
				r.accepted = 1'b1;
				serve(1'b1, r.srv1_id, r.srv1_arr);
				serve(1'b1, r.srv2_id, r.srv2_arr);
				serve(1'b0, r.srv3_id, r.srv3_arr);
			end
			default: ;
			endcase
			r.served_total    = served[SERVED_W-1:0];
			r.arrival_count   = arr_fill[COUNT_W-1:0];
			r.departure_count = dep_fill[COUNT_W-1:0];
			due.push_back(r);
		endfunction

		function string fmt(dispatch_t r);
			return $sformatf("acc=%0d s1=%h/%0d s2=%h/%0d s3=%h/%0d tot=%0d arr=%0d dep=%0d",
				r.accepted, r.srv1_id, r.srv1_arr, r.srv2_id, r.srv2_arr,
				r.srv3_id, r.srv3_arr, r.served_total, r.arrival_count,
				r.departure_count);
		endfunction

		function void check_result(dispatch_t got);
			dispatch_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] result with no item pending: %s", $realtime, fmt(got));
				end
				return;
			end
			want = due.pop_front();
			if (got.accepted !== want.accepted || got.srv1_id !== want.srv1_id
					|| got.srv1_arr !== want.srv1_arr || got.srv2_id !== want.srv2_id
					|| got.srv2_arr !== want.srv2_arr || got.srv3_id !== want.srv3_id
					|| got.srv3_arr !== want.srv3_arr
					|| got.served_total !== want.served_total
					|| got.arrival_count !== want.arrival_count
					|| got.departure_count !== want.departure_count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] mismatch\n  expected %s\n  actual   %s", $realtime,
						fmt(want), fmt(got));
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                done;
	logic [MODE_W-1:0]   mode;
	logic [ID_W-1:0]     req_id;
	logic [PRIO_W-1:0]   req_priority;
	logic                accepted;
	logic [ID_W-1:0]     srv1_id;
	logic                srv1_from_arrival;
	logic [ID_W-1:0]     srv2_id;
	logic                srv2_from_arrival;
	logic [ID_W-1:0]     srv3_id;
	logic                srv3_from_arrival;
	logic [SERVED_W-1:0] served_total;
	logic [COUNT_W-1:0]  arrival_count;
	logic [COUNT_W-1:0]  departure_count;

	dispatch_tracker tracker;
	int idle_pct;
	int cycle_cnt;

	priority_runway_dispatcher dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.done              (done),
		.mode              (mode),
		.req_id            (req_id),
		.req_priority      (req_priority),
		.accepted          (accepted),
		.srv1_id           (srv1_id),
		.srv1_from_arrival (srv1_from_arrival),
		.srv2_id           (srv2_id),
		.srv2_from_arrival (srv2_from_arrival),
		.srv3_id           (srv3_id),
		.srv3_from_arrival (srv3_from_arrival),
		.served_total      (served_total),
		.arrival_count     (arrival_count),
		.departure_count   (departure_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// check before noting: at an edge that takes a new item, the result is the older one
	always @(posedge clk) begin : monitor
		dispatch_t got;
		if (arst_n) begin
			if (done) begin
				got.accepted        = accepted;
				got.srv1_id         = srv1_id;
				got.srv1_arr        = srv1_from_arrival;
				got.srv2_id         = srv2_id;
				got.srv2_arr        = srv2_from_arrival;
				got.srv3_id         = srv3_id;
				got.srv3_arr        = srv3_from_arrival;
				got.served_total    = served_total;
				got.arrival_count   = arrival_count;
				got.departure_count = departure_count;
				tracker.check_result(got);
			end
			if (start && !busy) begin
				tracker.note_item(mode, req_id, req_priority);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [ID_W-1:0] rand_id();
		case ($urandom_range(19))
		0: return '0;
		1: return '1;
		default: return ID_W'($urandom_range(65535, 1));
		endcase
	endfunction

	// entered and left at a falling edge; start stays high for a back-to-back item
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] pr);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode         <= m;
		req_id       <= id;
		req_priority <= pr;
		start        <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic random_traffic(input int n_items, input int hold_at);
		int tick_pct;
		int r;
		logic [MODE_W-1:0] m;
		tick_pct = 25;
		for (int i = 0; i < n_items; i++) begin
			// every 40 items the tick share is drawn anew, so bursts fill or drain the stores
			if (i % 40 == 0) begin
				case ($urandom_range(2))
				0: tick_pct = 6;
				1: tick_pct = 25;
				default: tick_pct = 55;
				endcase
			end
			if (i == hold_at) begin
				drain();
			end
			r = $urandom_range(99);
			if (r < 3) begin
				m = MODE_UNUSED;
			end else if (r < 3 + tick_pct) begin
				m = MODE_TICK;
			end else if ($urandom_range(1) == 0) begin
				m = MODE_DEP;
			end else begin
				m = MODE_ARR;
			end
			send_item(m, rand_id(), PRIO_W'($urandom_range(7)));
		end
	endtask

	initial begin
		tracker      = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_DEP;
		req_id       = '0;
		req_priority = '0;
		idle_pct     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed
		send_item(MODE_TICK, 16'h0000, 3'd0);
		send_item(MODE_UNUSED, 16'h0005, 3'd2);
		send_item(MODE_DEP, 16'h0000, 3'd0);
		send_item(MODE_ARR, 16'h0000, 3'd3);
		send_item(MODE_DEP, 16'hFFFF, 3'd7);
		send_item(MODE_DEP, 16'h0001, 3'd0);
		send_item(MODE_ARR, 16'h8000, 3'd7);
		send_item(MODE_ARR, 16'h0001, 3'd0);
		send_item(MODE_ARR, 16'h00AA, 3'd7);
		send_item(MODE_ARR, 16'h5555, 3'd3);
		send_item(MODE_ARR, 16'hAAAA, 3'd3);
		send_item(MODE_TICK, 16'h3C3C, 3'd5);
		send_item(MODE_TICK, 16'h0000, 3'd7);
		send_item(MODE_TICK, 16'h0000, 3'd0);
		send_item(MODE_DEP, 16'h1234, 3'd4);
		send_item(MODE_DEP, 16'h4321, 3'd1);
		send_item(MODE_TICK, 16'hFFFF, 3'd0);
		// arrivals only: server 3 falls back to the arrival queue
		send_item(MODE_ARR, 16'h0777, 3'd5);
		send_item(MODE_ARR, 16'h0778, 3'd5);
		send_item(MODE_ARR, 16'h0779, 3'd0);
		send_item(MODE_TICK, 16'h0000, 3'd0);
		send_item(MODE_UNUSED, 16'hFFFF, 3'd7);

		idle_pct = 0;
		random_traffic(400, -1);
		idle_pct = 78;
		random_traffic(400, 200);
		idle_pct = 0;
		random_traffic(400, -1);
		idle_pct = 24;
		random_traffic(400, 150);

		// a few mixed rounds to finish
		idle_pct = 0;
		for (int k = 0; k < 12; k++) begin
			send_item(MODE_DEP, rand_id(), PRIO_W'($urandom_range(7)));
			send_item(MODE_TICK, rand_id(), PRIO_W'($urandom_range(7)));
		end

		start <= 1'b0;
		while (tracker.due.size() != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
		tracker.mismatches += tracker.due.size();
		if (tracker.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/prd_pkg.sv
rtl/core/prd_ram.sv
rtl/core/prd_seq.sv
rtl/core/priority_runway_dispatcher.sv
rtl/core/prd_checker.sv
dv/priority_runway_dispatcher_tb.sv
